/* rtl/spm_pkg.sv */
// Shared types and constants of the sparse polynomial multiplier.
// No dependencies; used by the top level.
package spm_pkg;

  localparam int COEF_W  = 16;
  localparam int EXPO_W  = 16;
  localparam int PCOEF_W = 38;
  localparam int PEXP_W  = 17;
  localparam int TERM_W  = COEF_W + EXPO_W;

  localparam logic signed [PCOEF_W-1:0] PCOEF_MAX = {1'b0, {(PCOEF_W-1){1'b1}}};
  localparam logic signed [PCOEF_W-1:0] PCOEF_MIN = {1'b1, {(PCOEF_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic signed [EXPO_W-1:0] expo;
  } term_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_TREAD,
    ST_MUL,
    ST_SEARCH,
    ST_CMP,
    ST_SCAN,
    ST_SCMP,
    ST_OUT
  } state_e;

endpackage

/* rtl/spm_ram.sv */
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// No dependencies.
module spm_ram #(
  parameter int DEPTH = 8,
  parameter int DW    = 32,
  parameter int AW    = 3
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/sparse_polynomial_multiplier.sv */
// Top level of the sparse polynomial multiplier: load control, product/merge
// sequencer and sorted emit. Depends on spm_pkg and spm_ram.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one term per beat. req_type_i
//    selects the operand; last_term_i on a second-operand beat starts the job.
//    Load beats are taken one per cycle while the block is loading.
//  - A term that finds its store full is dropped; overflow_o is then set on
//    every result of that job. A dropped term with last_term_i still starts it.
//  - The job walks every term pair: two term-RAM reads, one 16x16 multiply,
//    then a linear search of the product table RAM and a read-modify-write
//    merge, or an append when the pair's exponent is new to the table.
//  - Results leave in descending exponent order. Each result costs one scan of
//    the table plus the output beat; is_last_o flags the final one. An empty
//    operand gives no result beat.
//  - in_ready_o is low from job start until the last result beat is taken.
//    A stalled receiver simply holds the result beat; nothing is lost.
//  - Reset clears counts, flags and the sequencer; RAM contents are not cleared
//    since every job rebuilds the table from empty.
module sparse_polynomial_multiplier #(
  parameter int MAX_TERMS_A   = 8,
  parameter int MAX_TERMS_B   = 8,
  parameter int PRODUCT_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic signed [spm_pkg::COEF_W-1:0]  coefficient_i,
  input  logic signed [spm_pkg::EXPO_W-1:0]  exponent_i,
  input  logic                               last_term_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [spm_pkg::PCOEF_W-1:0] product_coefficient_o,
  output logic signed [spm_pkg::PEXP_W-1:0]  product_exponent_o,
  output logic                               is_last_o,
  output logic                               overflow_o
);

  localparam int CAP     = (PRODUCT_DEPTH < 64) ? PRODUCT_DEPTH : 64;
  localparam int IA_W    = (MAX_TERMS_A > 1) ? $clog2(MAX_TERMS_A) : 1;
  localparam int IB_W    = (MAX_TERMS_B > 1) ? $clog2(MAX_TERMS_B) : 1;
  localparam int TI_W    = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CA_W    = $clog2(MAX_TERMS_A + 1);
  localparam int CB_W    = $clog2(MAX_TERMS_B + 1);
  localparam int CU_W    = $clog2(CAP + 1);
  localparam int GROW_W  = 32 + $clog2(MAX_TERMS_A * MAX_TERMS_B) + 1;
  localparam int ACC_W   = (GROW_W > spm_pkg::PCOEF_W) ? GROW_W : spm_pkg::PCOEF_W;
  localparam int PEXP_W  = spm_pkg::PEXP_W;
  localparam int ENT_W   = ACC_W + PEXP_W;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(spm_pkg::PCOEF_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(spm_pkg::PCOEF_MIN);

  spm_pkg::state_e state_q, state_d;

  logic [CA_W-1:0] na_q, na_d, i_q, i_d;
  logic [CB_W-1:0] nb_q, nb_d, j_q, j_d;
  logic [CU_W-1:0] used_q, used_d, k_q, k_d, emitted_q, emitted_d;
  logic            drop_q, drop_d, over_q, over_d;
  logic            have_q, have_d, first_q, first_d;

  logic signed [31:0]       prod_q, prod_d;
  logic signed [PEXP_W-1:0] pexp_q, pexp_d;
  logic signed [PEXP_W-1:0] best_exp_q, best_exp_d, bound_q, bound_d;
  logic signed [ACC_W-1:0]  best_coef_q, best_coef_d;

  logic signed [spm_pkg::PCOEF_W-1:0] out_coef_q, out_coef_d;
  logic signed [PEXP_W-1:0]           out_exp_q, out_exp_d;
  logic                               out_last_q, out_last_d;

  // term stores
  logic                      a_we, b_we, t_re;
  logic [spm_pkg::TERM_W-1:0] a_rd, b_rd;
  spm_pkg::term_t            a_term, b_term, in_term;

  // product table
  logic             tb_we, tb_re;
  logic [TI_W-1:0]  tb_waddr;
  logic [ENT_W-1:0] tb_wdata, tb_rd;
  logic signed [ACC_W-1:0]  tb_coef;
  logic signed [PEXP_W-1:0] tb_exp;
  logic signed [ACC_W-1:0]  prod_ext;

  logic signed [ACC_W-1:0]  sel_coef;
  logic signed [PEXP_W-1:0] sel_exp;
  logic                     cand;
  logic                     last_pair;
  logic                     in_acc;

  assign in_term.coef = coefficient_i;
  assign in_term.expo = exponent_i;
  assign a_term       = a_rd;
  assign b_term       = b_rd;
  assign tb_coef      = $signed(tb_rd[ENT_W-1:PEXP_W]);
  assign tb_exp       = $signed(tb_rd[PEXP_W-1:0]);
  assign prod_ext     = {{(ACC_W-32){prod_q[31]}}, prod_q};

  spm_ram #(.DEPTH(MAX_TERMS_A), .DW(spm_pkg::TERM_W), .AW(IA_W)) u_store_a (
    .clk_i     (clk_i),
    .wr_en_i   (a_we),
    .wr_addr_i (na_q[IA_W-1:0]),
    .wr_data_i (in_term),
    .rd_en_i   (t_re),
    .rd_addr_i (i_q[IA_W-1:0]),
    .rd_data_o (a_rd)
  );

  spm_ram #(.DEPTH(MAX_TERMS_B), .DW(spm_pkg::TERM_W), .AW(IB_W)) u_store_b (
    .clk_i     (clk_i),
    .wr_en_i   (b_we),
    .wr_addr_i (nb_q[IB_W-1:0]),
    .wr_data_i (in_term),
    .rd_en_i   (t_re),
    .rd_addr_i (j_q[IB_W-1:0]),
    .rd_data_o (b_rd)
  );

  spm_ram #(.DEPTH(CAP), .DW(ENT_W), .AW(TI_W)) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tb_we),
    .wr_addr_i (tb_waddr),
    .wr_data_i (tb_wdata),
    .rd_en_i   (tb_re),
    .rd_addr_i (k_q[TI_W-1:0]),
    .rd_data_o (tb_rd)
  );

  assign in_ready_o            = (state_q == spm_pkg::ST_LOAD);
  assign in_acc                = in_valid_i && in_ready_o;
  assign out_valid_o           = (state_q == spm_pkg::ST_OUT);
  assign product_coefficient_o = out_coef_q;
  assign product_exponent_o    = out_exp_q;
  assign is_last_o             = out_last_q;
  assign overflow_o            = over_q;

  assign last_pair = (i_q == na_q - CA_W'(1)) && (j_q == nb_q - CB_W'(1));

  // candidate for the next emitted entry: below the last emitted exponent,
  // above the best seen so far in this scan
  assign cand     = (first_q || (tb_exp < bound_q)) && (!have_q || (tb_exp > best_exp_q));
  assign sel_coef = cand ? tb_coef : best_coef_q;
  assign sel_exp  = cand ? tb_exp  : best_exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spm_pkg::ST_LOAD;
      na_q      <= '0;
      nb_q      <= '0;
      drop_q    <= 1'b0;
      over_q    <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      used_q    <= '0;
      k_q       <= '0;
      emitted_q <= '0;
      have_q    <= 1'b0;
      first_q   <= 1'b1;
    end else begin
      state_q   <= state_d;
      na_q      <= na_d;
      nb_q      <= nb_d;
      drop_q    <= drop_d;
      over_q    <= over_d;
      i_q       <= i_d;
      j_q       <= j_d;
      used_q    <= used_d;
      k_q       <= k_d;
      emitted_q <= emitted_d;
      have_q    <= have_d;
      first_q   <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    pexp_q      <= pexp_d;
    best_exp_q  <= best_exp_d;
    best_coef_q <= best_coef_d;
    bound_q     <= bound_d;
    out_coef_q  <= out_coef_d;
    out_exp_q   <= out_exp_d;
    out_last_q  <= out_last_d;
  end

  always_comb begin
    logic [CB_W-1:0] nb_new;
    logic            drop_new;

    state_d     = state_q;
    na_d        = na_q;
    nb_d        = nb_q;
    drop_d      = drop_q;
    over_d      = over_q;
    i_d         = i_q;
    j_d         = j_q;
    used_d      = used_q;
    k_d         = k_q;
    emitted_d   = emitted_q;
    have_d      = have_q;
    first_d     = first_q;
    prod_d      = prod_q;
    pexp_d      = pexp_q;
    best_exp_d  = best_exp_q;
    best_coef_d = best_coef_q;
    bound_d     = bound_q;
    out_coef_d  = out_coef_q;
    out_exp_d   = out_exp_q;
    out_last_d  = out_last_q;
    a_we        = 1'b0;
    b_we        = 1'b0;
    t_re        = 1'b0;
    tb_we       = 1'b0;
    tb_re       = 1'b0;
    tb_waddr    = k_q[TI_W-1:0];
    tb_wdata    = {tb_coef + prod_ext, pexp_q};
    nb_new      = nb_q;
    drop_new    = drop_q;

    case (state_q)
      spm_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (!req_type_i) begin
            if (na_q < CA_W'(MAX_TERMS_A)) begin
              a_we = 1'b1;
              na_d = na_q + CA_W'(1);
            end else begin
              drop_d = 1'b1;
            end
          end else begin
            if (nb_q < CB_W'(MAX_TERMS_B)) begin
              b_we   = 1'b1;
              nb_new = nb_q + CB_W'(1);
            end else begin
              drop_new = 1'b1;
            end
            nb_d   = nb_new;
            drop_d = drop_new;
            if (last_term_i) begin
              if ((na_q == '0) || (nb_new == '0)) begin
                na_d   = '0;
                nb_d   = '0;
                drop_d = 1'b0;
              end else begin
                over_d  = drop_new;
                i_d     = '0;
                j_d     = '0;
                used_d  = '0;
                state_d = spm_pkg::ST_TREAD;
              end
            end
          end
        end
      end
      spm_pkg::ST_TREAD: begin
        t_re    = 1'b1;
        state_d = spm_pkg::ST_MUL;
      end
      spm_pkg::ST_MUL: begin
        prod_d  = a_term.coef * b_term.coef;
        pexp_d  = PEXP_W'(a_term.expo) + PEXP_W'(b_term.expo);
        k_d     = '0;
        state_d = spm_pkg::ST_SEARCH;
      end
      spm_pkg::ST_SEARCH, spm_pkg::ST_CMP: begin
        if (state_q == spm_pkg::ST_SEARCH && k_q != used_q) begin
          tb_re   = 1'b1;
          state_d = spm_pkg::ST_CMP;
        end else if (state_q == spm_pkg::ST_CMP && tb_exp != pexp_q) begin
          k_d     = k_q + CU_W'(1);
          state_d = spm_pkg::ST_SEARCH;
        end else begin
          // merge on a hit, append on a miss, drop when the table is full
          if (state_q == spm_pkg::ST_CMP) begin
            tb_we = 1'b1;
          end else if (used_q < CU_W'(CAP)) begin
            tb_we    = 1'b1;
            tb_waddr = used_q[TI_W-1:0];
            tb_wdata = {prod_ext, pexp_q};
            used_d   = used_q + CU_W'(1);
          end else begin
            over_d = 1'b1;
          end
          if (last_pair) begin
            k_d       = '0;
            have_d    = 1'b0;
            first_d   = 1'b1;
            emitted_d = '0;
            state_d   = spm_pkg::ST_SCAN;
          end else begin
            if (j_q == nb_q - CB_W'(1)) begin
              j_d = '0;
              i_d = i_q + CA_W'(1);
            end else begin
              j_d = j_q + CB_W'(1);
            end
            state_d = spm_pkg::ST_TREAD;
          end
        end
      end
      spm_pkg::ST_SCAN: begin
        tb_re   = 1'b1;
        state_d = spm_pkg::ST_SCMP;
      end
      spm_pkg::ST_SCMP: begin
        // best stays empty until a real candidate shows up
        have_d      = have_q | cand;
        best_coef_d = sel_coef;
        best_exp_d  = sel_exp;
        if (k_q == used_q - CU_W'(1)) begin
          if (sel_coef > SAT_HI) begin
            out_coef_d = spm_pkg::PCOEF_MAX;
          end else if (sel_coef < SAT_LO) begin
            out_coef_d = spm_pkg::PCOEF_MIN;
          end else begin
            out_coef_d = sel_coef[spm_pkg::PCOEF_W-1:0];
          end
          out_exp_d  = sel_exp;
          out_last_d = (emitted_q == used_q - CU_W'(1));
          state_d    = spm_pkg::ST_OUT;
        end else begin
          k_d     = k_q + CU_W'(1);
          state_d = spm_pkg::ST_SCAN;
        end
      end
      spm_pkg::ST_OUT: begin
        if (out_ready_i) begin
          bound_d   = out_exp_q;
          first_d   = 1'b0;
          emitted_d = emitted_q + CU_W'(1);
          k_d       = '0;
          have_d    = 1'b0;
          if (out_last_q) begin
            na_d    = '0;
            nb_d    = '0;
            drop_d  = 1'b0;
            state_d = spm_pkg::ST_LOAD;
          end else begin
            state_d = spm_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_d = spm_pkg::ST_LOAD;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_load_during_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a result beat is pending");

  a_table_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CU_W'(CAP))
    else $error("product table fill count beyond capacity");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (emitted_q < used_q))
    else $error("more result beats than table entries");

  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && is_last_o) |=> (in_ready_o && na_q == '0 && nb_q == '0))
    else $error("job did not return to loading after final beat");

endmodule

/* verif/sparse_polynomial_multiplier_tb.sv */
// Self-checking testbench for sparse_polynomial_multiplier: term beats in, sorted
// product beats out, checked against a behavioral scoreboard. Depends on spm_pkg.
`timescale 1ns / 100ps

module sparse_polynomial_multiplier_tb;

  localparam int DEPTH_A = 8;
  localparam int DEPTH_B = 8;
  localparam int TABLE_MAX = 64;

  typedef struct {
    logic signed [spm_pkg::PCOEF_W-1:0] coef;
    logic signed [spm_pkg::PEXP_W-1:0]  expo;
    logic                               last;
    logic                               ovf;
  } product_t;

  // Holds both term stores and the queue of product beats still owed by the block.
  class poly_scoreboard;
    logic signed [15:0] a_coef[DEPTH_A], a_expo[DEPTH_A];
    logic signed [15:0] b_coef[DEPTH_B], b_expo[DEPTH_B];
    int unsigned a_cnt, b_cnt;
    bit dropped;
    product_t owed[$];
    int errors;

    function new();
      a_cnt = 0; b_cnt = 0; dropped = 0; errors = 0;
    endfunction

    function void multiply_out();
      longint acc[TABLE_MAX];
      int     ex[TABLE_MAX];
      int     used, k, e;
      bit     hit, ovf;
      longint p, tc;
      int     te;
      product_t r;
      used = 0;
      ovf = dropped;
      if (a_cnt != 0 && b_cnt != 0) begin
        for (int i = 0; i < a_cnt; i++) begin
          for (int j = 0; j < b_cnt; j++) begin
            p = longint'(a_coef[i]) * longint'(b_coef[j]);
            e = int'(a_expo[i]) + int'(b_expo[j]);
            hit = 0;
            for (k = 0; k < used; k++) begin
              if (ex[k] == e) begin
                acc[k] += p;
                hit = 1;
                break;
              end
            end
            if (!hit) begin
              if (used < TABLE_MAX) begin
                acc[used] = p; ex[used] = e; used++;
              end else begin
                ovf = 1;
              end
            end
          end
        end
        // descending exponent
        for (int i = 1; i < used; i++) begin
          tc = acc[i]; te = ex[i]; k = i;
          while (k > 0 && ex[k-1] < te) begin
            acc[k] = acc[k-1]; ex[k] = ex[k-1]; k--;
          end
          acc[k] = tc; ex[k] = te;
        end
        for (int i = 0; i < used; i++) begin
          tc = acc[i];
          if (tc > (64'sd1 <<< 37) - 1) tc = (64'sd1 <<< 37) - 1;
          if (tc < -(64'sd1 <<< 37)) tc = -(64'sd1 <<< 37);
          r.coef = tc[spm_pkg::PCOEF_W-1:0];
          r.expo = e_trunc(ex[i]);
          r.last = (i + 1 == used);
          r.ovf  = ovf;
          owed.push_back(r);
        end
      end
      a_cnt = 0; b_cnt = 0; dropped = 0;
    endfunction

    function logic signed [spm_pkg::PEXP_W-1:0] e_trunc(int v);
      return v[spm_pkg::PEXP_W-1:0];
    endfunction

    function void note_beat(bit second, logic signed [15:0] c, logic signed [15:0] e,
                            bit last);
      if (!second) begin
        if (a_cnt < DEPTH_A) begin
          a_coef[a_cnt] = c; a_expo[a_cnt] = e; a_cnt++;
        end else dropped = 1;
      end else begin
        if (b_cnt < DEPTH_B) begin
          b_coef[b_cnt] = c; b_expo[b_cnt] = e; b_cnt++;
        end else dropped = 1;
        if (last) multiply_out();
      end
    endfunction

    function void check_result(logic signed [spm_pkg::PCOEF_W-1:0] c,
                               logic signed [spm_pkg::PEXP_W-1:0] e, bit l, bit o);
      product_t x;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected product beat: coef %0d exp %0d", c, e);
        return;
      end
      x = owed.pop_front();
      if (x.coef !== c || x.expo !== e || x.last !== l || x.ovf !== o) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp coef %0d exp %0d last %0b ovf %0b, got %0d %0d %0b %0b",
                   x.coef, x.expo, x.last, x.ovf, c, e, l, o);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic req_type_i = 1'b0;
  logic signed [spm_pkg::COEF_W-1:0] coefficient_i = '0;
  logic signed [spm_pkg::EXPO_W-1:0] exponent_i = '0;
  logic last_term_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [spm_pkg::PCOEF_W-1:0] product_coefficient_o;
  logic signed [spm_pkg::PEXP_W-1:0]  product_exponent_o;
  logic is_last_o;
  logic overflow_o;

  poly_scoreboard sb = new();
  int  beats_sent = 0;
  bit  no_idle = 0;   // stretches with back-to-back beats

  always #10 clk_i = ~clk_i;

  sparse_polynomial_multiplier dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .coefficient_i,
    .exponent_i, .last_term_i, .out_valid_o, .out_ready_i, .product_coefficient_o,
    .product_exponent_o, .is_last_o, .overflow_o
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [15:0] pick_val(bit narrow);
    int r;
    r = $urandom_range(0, 9);
    if (narrow) return 16'($urandom_range(0, 7)) - 16'sd3;
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    return 16'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(bit second, logic signed [15:0] c, logic signed [15:0] e,
                           bit last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    req_type_i = second;
    coefficient_i = c;
    exponent_i = e;
    last_term_i = last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(second, c, e, last);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // One job: na first-operand terms and nb second-operand terms, interleaved,
  // the final second-operand beat carrying last_term.
  task automatic random_job(int na, int nb, bit narrow);
    int ra, rb;
    bit pick_b;
    ra = na; rb = nb;
    while (ra + rb > 0) begin
      if (ra == 0) pick_b = 1;
      else if (rb <= 1) pick_b = 0;
      else pick_b = $urandom_range(0, 1);
      if (rb == 1 && ra == 0) begin
        send_beat(1, pick_val(0), pick_val(narrow), 1);
        rb--;
      end else if (pick_b) begin
        send_beat(1, pick_val(0), pick_val(narrow), 0);
        rb--;
      end else begin
        // last_term on a first-operand beat is a plain load
        send_beat(0, pick_val(0), pick_val(narrow), $urandom_range(0, 7) == 0);
        ra--;
      end
    end
  endtask

  // receiver: random stalls on the result channel
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      g = pick_gap();
      if (g > 0) begin
        out_ready_i = 1'b0;
        repeat (g) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(product_coefficient_o, product_exponent_o, is_last_o, overflow_o);
  end

  initial begin
    int waited;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // extremes: max positive product, top and bottom exponents
    send_beat(0, 16'sh8000, 16'sh7fff, 0);
    send_beat(0, 16'sh7fff, 16'sh8000, 0);
    send_beat(1, 16'sh8000, 16'sh7fff, 0);
    send_beat(1, 16'sh7fff, 16'sh8000, 1);
    // zero sum kept
    send_beat(0, 16'sd1, 16'sd0, 0);
    send_beat(0, 16'sd1, 16'sd1, 1);      // flag ignored on first operand
    send_beat(1, 16'sd1, 16'sd1, 0);
    send_beat(1, -16'sd1, 16'sd0, 1);
    // empty first operand: no result
    send_beat(1, 16'sd5, 16'sd2, 1);
    // full first store: ninth term dropped
    for (int i = 0; i < 9; i++) send_beat(0, 16'(i + 1), 16'(i), 0);
    send_beat(1, 16'sd3, -16'sd4, 1);
    // full table: 64 distinct exponents, dropped last term still starts the job
    for (int i = 0; i < 8; i++) send_beat(0, 16'($urandom), 16'(i), 0);
    for (int i = 0; i < 8; i++) send_beat(1, 16'($urandom), 16'(8 * i), 0);
    send_beat(1, 16'sd7, 16'sd7, 1);

    while (beats_sent < 100) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0:       random_job(0, $urandom_range(1, 3), 0);
        1:       random_job(9, 9, $urandom_range(0, 1));
        default: random_job($urandom_range(1, 4), $urandom_range(1, 4),
                            $urandom_range(0, 1));
      endcase
    end
    no_idle = 0;
    in_valid_i = 1'b0;

    waited = 0;
    while (sb.owed.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/spm_pkg.sv
rtl/spm_ram.sv
rtl/sparse_polynomial_multiplier.sv
verif/sparse_polynomial_multiplier_tb.sv
